>>> hdl/fcd_pkg.sv
// ============================================================================
// fcd_pkg: shared constants and types of the FAST corner detector
// Field widths, register codes and reset values, and the placement of the
// sixteen circle taps and the centre in the pixel window.
// ============================================================================
package fcd_pkg;

    localparam int LINE_WIDTH_DEF = 128;
    localparam int PIXEL_BITS_DEF = 8;

    // configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 10;
    localparam int THRESH_W    = 8;
    localparam int ROWS_W      = 10;
    localparam int COLS_W      = 8;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_THRESHOLD   = 2'd0,
        CFG_ACTIVE_ROWS = 2'd1,
        CFG_ACTIVE_COLS = 2'd2
    } cfg_reg_t;

    localparam logic [THRESH_W-1:0] THRESH_RESET   = 8'd20;
    localparam logic [ROWS_W-1:0]   ROWS_RESET     = 10'd128;
    localparam logic [COLS_W-1:0]   COLS_RESET     = 8'd128;
    // mark row starts at minus four (two's complement)
    localparam logic [ROWS_W-1:0]   MARK_ROW_RESET = 10'h3FC;

    // result fields
    localparam int OUT_ROW_W = 9;
    localparam int OUT_COL_W = 7;
    localparam int MARK_W    = 8;
    localparam logic [MARK_W-1:0] MARK_CORNER = 8'hFF;
    localparam logic [MARK_W-1:0] MARK_NONE   = 8'h00;

    // circle radius, also the width of the unmarked border
    localparam int BORDER = 3;

    // window: six stored lines plus the live pixel, seven column stages
    localparam int LINE_ROWS  = 6;
    localparam int WIN_ROWS   = 7;
    localparam int WIN_STAGES = 7;
    // line memory is read this many columns ahead of the write column
    localparam int READ_AHEAD = 2;

    localparam int CIRCLE_N = 16;
    localparam int SOFT_W   = 5;
    localparam int HARD_W   = 3;
    localparam logic [SOFT_W-1:0] SOFT_MIN = 5'd12;
    localparam logic [HARD_W-1:0] HARD_MIN = 3'd3;

    // tap k sits at window row CIRCLE_ROW[k] (0 = newest line) and column
    // stage CIRCLE_STAGE[k]; compass points are the taps with k a multiple of 4
    localparam int CIRCLE_ROW [CIRCLE_N] =
        '{3, 4, 5, 6, 6, 6, 5, 4, 3, 2, 1, 0, 0, 0, 1, 2};
    localparam int CIRCLE_STAGE [CIRCLE_N] =
        '{6, 6, 5, 4, 3, 2, 1, 0, 0, 0, 1, 0, 1, 2, 5, 6};
    localparam int CENTRE_ROW   = 3;
    localparam int CENTRE_STAGE = 3;

endpackage

>>> hdl/fcd_if.sv
// ============================================================================
// fcd_if: valid/ready stream channels of the FAST corner detector
// fcd_pixel_if carries one input pixel per beat, fcd_mark_if one mark result.
// ============================================================================
interface fcd_pixel_if #(
    parameter int PIXEL_BITS = fcd_pkg::PIXEL_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [PIXEL_BITS-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

interface fcd_mark_if;
    logic                           valid;
    logic                           ready;
    logic [fcd_pkg::OUT_ROW_W-1:0]  out_row;
    logic [fcd_pkg::OUT_COL_W-1:0]  out_col;
    logic [fcd_pkg::MARK_W-1:0]     corner_mark;

    modport source (output valid, output out_row, output out_col, output corner_mark,
                    input ready);
    modport sink   (input valid, input out_row, input out_col, input corner_mark,
                    output ready);
endinterface

>>> hdl/fcd_window.sv
// ============================================================================
// fcd_window: line memory and 7x7 pixel window
// One memory word per column holds that column's pixels of the last six lines.
// Each beat reads the word READ_AHEAD columns ahead and writes back the word of
// the current column with its lines moved down by one.
// ============================================================================
module fcd_window #(
    parameter int LINE_WIDTH = fcd_pkg::LINE_WIDTH_DEF,
    parameter int PIXEL_BITS = fcd_pkg::PIXEL_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          shift,
    input  logic [PIXEL_BITS-1:0]         pixel,
    input  logic [$clog2(LINE_WIDTH)-1:0] col,
    output logic [PIXEL_BITS-1:0]         circle [fcd_pkg::CIRCLE_N],
    output logic [PIXEL_BITS-1:0]         centre
);
    import fcd_pkg::*;

    localparam int COL_W  = $clog2(LINE_WIDTH);
    localparam int WORD_W = LINE_ROWS * PIXEL_BITS;
    localparam int VEC_W  = WIN_ROWS * PIXEL_BITS;

    logic [WORD_W-1:0]     line_mem [LINE_WIDTH];
    logic [WORD_W-1:0]     rd_reg;
    logic [PIXEL_BITS-1:0] px_reg;
    logic [VEC_W-1:0]      stage_reg [1:WIN_STAGES-1];
    logic [VEC_W-1:0]      vec [WIN_STAGES];
    logic [COL_W:0]        ahead;
    logic [COL_W-1:0]      rd_addr;
    logic [WORD_W-1:0]     wr_word;

    assign ahead   = {1'b0, col} + (COL_W+1)'(READ_AHEAD);
    assign rd_addr = (ahead >= (COL_W+1)'(LINE_WIDTH))
                     ? COL_W'(ahead - (COL_W+1)'(LINE_WIDTH))
                     : ahead[COL_W-1:0];

    // the word read two beats ago for this column, moved down one line
    assign wr_word = {stage_reg[1][WORD_W-1:PIXEL_BITS], pixel};

    // the write column never equals the read column, no forwarding needed
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            line_mem[col] <= wr_word;
            rd_reg        <= line_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            px_reg       <= pixel;
            stage_reg[1] <= vec[0];
            for (int s = 2; s < WIN_STAGES; s++)
            begin
                stage_reg[s] <= stage_reg[s-1];
            end
        end
    end

    always_comb
    begin
        vec[0] = {rd_reg, px_reg};
        for (int s = 1; s < WIN_STAGES; s++)
        begin
            vec[s] = stage_reg[s];
        end
    end

    always_comb
    begin
        for (int k = 0; k < CIRCLE_N; k++)
        begin
            circle[k] = vec[CIRCLE_STAGE[k]][CIRCLE_ROW[k]*PIXEL_BITS +: PIXEL_BITS];
        end
        centre = vec[CENTRE_STAGE][CENTRE_ROW*PIXEL_BITS +: PIXEL_BITS];
    end

endmodule

>>> hdl/fast_corner_detector.sv
// ============================================================================
// fast_corner_detector: streaming FAST corner test on a 16-pixel circle
// Pixels arrive in raster order; each beat marks the pixel three lines and
// one column back as corner (255) or not (0).
//
//   channel   | role   | payload                         | beat taken when
//   ----------+--------+---------------------------------+-------------------
//   pixels    | sink   | pixel                           | valid && ready
//   marks     | source | out_row, out_col, corner_mark   | valid && ready
//   cfg_*     | write  | cfg_index, cfg_data             | cfg_wr_en
//
// One pixel per clock unless marks stalls; the line memory does one read and
// one write per beat. A result passes the window, score and output stages.
// Reset clears counters, valids and registers; the line memory is not cleared,
// its words reach a mark only after six full lines have passed through.
// A stall on marks holds the output, then the score stage, then pixels.ready.
// ============================================================================
module fast_corner_detector #(
    parameter int LINE_WIDTH = fcd_pkg::LINE_WIDTH_DEF,
    parameter int PIXEL_BITS = fcd_pkg::PIXEL_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [fcd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [fcd_pkg::CFG_DATA_W-1:0]  cfg_data,
    fcd_pixel_if.sink                       pixels,
    fcd_mark_if.source                      marks
);
    import fcd_pkg::*;

    localparam int COL_W  = $clog2(LINE_WIDTH);
    localparam int CMP_W  = 12;
    localparam int DCMP_W = (PIXEL_BITS > THRESH_W) ? PIXEL_BITS : THRESH_W;
    localparam logic [COL_W-1:0] COL_LAST = COL_W'(LINE_WIDTH - 1);
    localparam logic signed [CMP_W-1:0] BORDER_S = CMP_W'(BORDER);

    // configuration
    logic [THRESH_W-1:0] threshold_reg;
    logic [ROWS_W-1:0]   active_rows_reg;
    logic [COLS_W-1:0]   active_cols_reg;

    // position counters
    logic [ROWS_W-1:0] in_row_reg, in_row_next;
    logic [COL_W-1:0]  in_col_reg, in_col_next;
    logic [ROWS_W-1:0] mark_row_reg, mark_row_next;
    logic [COL_W-1:0]  mark_col_reg, mark_col_next;

    // handshake
    logic pix_acc;
    logic out_take;
    logic p1_ready;
    logic w_adv;

    // input gating and mark placement
    logic                    in_active;
    logic [PIXEL_BITS-1:0]   pixel_gated;
    logic signed [CMP_W-1:0] mrow_s, mcol_s, rows_lim, cols_lim;
    logic                    show;
    logic                    inner;

    // window stage
    logic                 w_vld_reg, w_vld_next;
    logic                 w_show_reg, w_inner_reg;
    logic [OUT_ROW_W-1:0] w_row_reg;
    logic [OUT_COL_W-1:0] w_col_reg;
    logic [PIXEL_BITS-1:0] circle [CIRCLE_N];
    logic [PIXEL_BITS-1:0] centre;
    logic [CIRCLE_N-1:0]   pass;

    // score stage
    logic                 p1_vld_reg, p1_vld_next;
    logic [CIRCLE_N-1:0]  p1_pass_reg;
    logic                 p1_inner_reg;
    logic [OUT_ROW_W-1:0] p1_row_reg;
    logic [OUT_COL_W-1:0] p1_col_reg;
    logic [SOFT_W-1:0]    ring_count;
    logic [HARD_W-1:0]    compass_count;
    logic                 is_corner;

    // output stage
    logic                 out_vld_reg, out_vld_next;
    logic [OUT_ROW_W-1:0] out_row_reg;
    logic [OUT_COL_W-1:0] out_col_reg;
    logic [MARK_W-1:0]    out_mark_reg;

    // ------------------------------------------------------------------------
    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg   <= THRESH_RESET;
            active_rows_reg <= ROWS_RESET;
            active_cols_reg <= COLS_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_THRESHOLD:   threshold_reg   <= cfg_data[THRESH_W-1:0];
                CFG_ACTIVE_ROWS: active_rows_reg <= cfg_data[ROWS_W-1:0];
                CFG_ACTIVE_COLS: active_cols_reg <= cfg_data[COLS_W-1:0];
                default:         ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // handshake chain
    assign out_take     = !out_vld_reg || marks.ready;
    assign p1_ready     = !p1_vld_reg || out_take;
    assign w_adv        = w_vld_reg && p1_ready;
    assign pixels.ready = !w_vld_reg || p1_ready;
    assign pix_acc      = pixels.valid && pixels.ready;

    // ------------------------------------------------------------------------
    // counters: a column wraps at the line end and carries into its row
    always_comb
    begin
        in_row_next   = in_row_reg;
        in_col_next   = in_col_reg;
        mark_row_next = mark_row_reg;
        mark_col_next = mark_col_reg;
        if (pix_acc)
        begin
            if (in_col_reg == COL_LAST)
            begin
                in_col_next = '0;
                in_row_next = in_row_reg + ROWS_W'(1);
            end
            else
            begin
                in_col_next = in_col_reg + COL_W'(1);
            end
            if (mark_col_reg == COL_LAST)
            begin
                mark_col_next = '0;
                mark_row_next = mark_row_reg + ROWS_W'(1);
            end
            else
            begin
                mark_col_next = mark_col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_row_reg   <= '0;
            in_col_reg   <= '0;
            mark_row_reg <= MARK_ROW_RESET;
            mark_col_reg <= COL_LAST;
        end
        else
        begin
            in_row_reg   <= in_row_next;
            in_col_reg   <= in_col_next;
            mark_row_reg <= mark_row_next;
            mark_col_reg <= mark_col_next;
        end
    end

    // ------------------------------------------------------------------------
    // zero pixels outside the active area; a negative row counts as active
    assign in_active = ($signed({in_row_reg[ROWS_W-1], in_row_reg})
                        < $signed({1'b0, active_rows_reg}))
                    && (CMP_W'(in_col_reg) < CMP_W'(active_cols_reg));
    assign pixel_gated = in_active ? pixels.pixel : '0;

    assign mrow_s   = CMP_W'($signed(mark_row_reg));
    assign mcol_s   = signed'(CMP_W'(mark_col_reg));
    assign rows_lim = signed'(CMP_W'(active_rows_reg)) - BORDER_S;
    assign cols_lim = signed'(CMP_W'(active_cols_reg)) - BORDER_S;

    assign show  = !mark_row_reg[ROWS_W-1]
                && (CMP_W'(mark_col_reg) < CMP_W'(active_cols_reg));
    assign inner = (mrow_s >= BORDER_S) && (mrow_s < rows_lim)
                && (mcol_s >= BORDER_S) && (mcol_s < cols_lim);

    fcd_window #(
        .LINE_WIDTH (LINE_WIDTH),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_window (
        .clk    (clk),
        .shift  (pix_acc),
        .pixel  (pixel_gated),
        .col    (in_col_reg),
        .circle (circle),
        .centre (centre)
    );

    // ------------------------------------------------------------------------
    // window stage: holds while its beat has not moved on
    always_comb
    begin
        w_vld_next = w_vld_reg;
        if (pix_acc)
        begin
            w_vld_next = 1'b1;
        end
        else if (w_adv)
        begin
            w_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_vld_reg <= 1'b0;
        end
        else
        begin
            w_vld_reg <= w_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_acc)
        begin
            w_show_reg  <= show;
            w_inner_reg <= inner;
            w_row_reg   <= mark_row_reg[OUT_ROW_W-1:0];
            w_col_reg   <= OUT_COL_W'(mark_col_reg);
        end
    end

    always_comb
    begin
        logic [PIXEL_BITS-1:0] diff;
        for (int k = 0; k < CIRCLE_N; k++)
        begin
            diff    = (centre > circle[k]) ? centre - circle[k] : circle[k] - centre;
            pass[k] = DCMP_W'(diff) > DCMP_W'(threshold_reg);
        end
    end

    // ------------------------------------------------------------------------
    // score stage: beats that give no result drop here
    always_comb
    begin
        p1_vld_next = p1_vld_reg;
        if (p1_ready)
        begin
            p1_vld_next = w_adv && w_show_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_vld_reg <= 1'b0;
        end
        else
        begin
            p1_vld_reg <= p1_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (w_adv)
        begin
            p1_pass_reg  <= pass;
            p1_inner_reg <= w_inner_reg;
            p1_row_reg   <= w_row_reg;
            p1_col_reg   <= w_col_reg;
        end
    end

    assign ring_count    = SOFT_W'($countones(p1_pass_reg));
    assign compass_count = HARD_W'(p1_pass_reg[0]) + HARD_W'(p1_pass_reg[4])
                         + HARD_W'(p1_pass_reg[8]) + HARD_W'(p1_pass_reg[12]);
    assign is_corner = p1_inner_reg && (compass_count >= HARD_MIN)
                    && (ring_count >= SOFT_MIN);

    // ------------------------------------------------------------------------
    // output register
    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (out_take)
        begin
            out_vld_next = p1_vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_take && p1_vld_reg)
        begin
            out_row_reg  <= p1_row_reg;
            out_col_reg  <= p1_col_reg;
            out_mark_reg <= is_corner ? MARK_CORNER : MARK_NONE;
        end
    end

    assign marks.valid       = out_vld_reg;
    assign marks.out_row     = out_row_reg;
    assign marks.out_col     = out_col_reg;
    assign marks.corner_mark = out_mark_reg;

    // ------------------------------------------------------------------------
    // the mark position trails the input position by three lines and a pixel
    a_mark_lag: assert property (@(posedge clk) disable iff (!rst_n)
        (mark_col_reg == COL_LAST)
            ? (in_col_reg == '0 && in_row_reg == mark_row_reg + ROWS_W'(BORDER + 1))
            : (in_col_reg == mark_col_reg + COL_W'(1)
               && in_row_reg == mark_row_reg + ROWS_W'(BORDER)))
        else $error("mark counters out of step with input counters");

    // a stalled score beat keeps its pass bits
    a_score_hold: assert property (@(posedge clk) disable iff (!rst_n)
        p1_vld_reg && !out_take |=> p1_vld_reg && $stable(p1_pass_reg))
        else $error("score stage changed while stalled");

    // a corner never lies in the top or left border
    a_corner_inside: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && out_mark_reg == MARK_CORNER
            |-> out_row_reg >= OUT_ROW_W'(BORDER) && out_col_reg >= OUT_COL_W'(BORDER))
        else $error("corner marked in the border");

endmodule
